// ===== src/hybrid_radix4_log_approx_multiplier_top_assert.svh =====
// assertion macros included by the top-level rtl file
`ifndef HYBRID_RADIX4_LOG_APPROX_MULTIPLIER_TOP_ASSERT_SVH
`define HYBRID_RADIX4_LOG_APPROX_MULTIPLIER_TOP_ASSERT_SVH

// same-cycle implication under reset
`define HRLAM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication under reset
`define HRLAM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/hrlam_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hrlam_pkg;

  localparam int OPND_W = 16;
  localparam int PROD_W = 32;
  localparam int LOW_W  = 15;
  localparam int MANT_W = 4;
  localparam int LOG_FRAC_W = 15;

  localparam logic [MANT_W-1:0] MANT_KEEP_RESET = 4'd3;
  localparam logic [MANT_W-1:0] MANT_KEEP_MIN   = 4'd1;

  typedef enum logic [0:0] {
    REG_MANT_KEEP = 1'b0
  } reg_idx_t;

  typedef struct packed {
    logic signed [LOW_W-1:0]  low;
    logic signed [OPND_W-1:0] mult;
    logic [MANT_W-1:0]        keep_bits;
  } log_opnd_t;

endpackage

`default_nettype wire

// ===== src/hrlam_log_path.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hrlam_log_path (
  input  wire hrlam_pkg::log_opnd_t          opnd,
  output logic [hrlam_pkg::PROD_W-1:0]       mag_out
);

  function automatic logic [3:0] lead_pos(input logic [15:0] v);
    logic [3:0] p;
    p = 4'd0;
    for (int i = 1; i < 16; i++) begin
      if (v[i]) begin
        p = 4'(i);
      end
    end
    return p;
  endfunction

  logic        a_neg, b_neg, is_zero;
  logic [13:0] ma;
  logic [14:0] mb;
  logic [3:0]  ka, kb;
  logic [15:0] xa, xb;
  logic [14:0] keep, rbit, ya, yb;
  logic [15:0] s;
  logic [4:0]  kl;
  logic [43:0] shifted;
  logic [31:0] mag;

  always_comb begin
    is_zero = (opnd.low == '0) || (opnd.mult == '0);
    a_neg   = opnd.low[hrlam_pkg::LOW_W-1];
    b_neg   = opnd.mult[hrlam_pkg::OPND_W-1];
    // one's complement magnitudes
    ma = a_neg ? 14'(~opnd.low) : 14'(opnd.low);
    mb = b_neg ? 15'(~opnd.mult) : 15'(opnd.mult);
    ka = lead_pos({2'b00, ma});
    kb = lead_pos({1'b0, mb});
    xa = 16'({2'b00, ma} << (4'd15 - ka));
    xb = 16'({1'b0, mb} << (4'd15 - kb));
    for (int i = 0; i < hrlam_pkg::LOG_FRAC_W; i++) begin
      keep[i] = (5'(i) + {1'b0, opnd.keep_bits}) >= 5'd16;
      rbit[i] = (5'(i) + {1'b0, opnd.keep_bits}) == 5'd15;
    end
    ya = (xa[14:0] & keep) | rbit;
    yb = (xb[14:0] & keep) | rbit;
    s  = {1'b0, ya} + {1'b0, yb};
    kl = {1'b0, ka} + {1'b0, kb} + {4'd0, s[15]};
    // fixed-point antilog
    shifted = {28'd0, 1'b1, s[14:0]} << kl;
    mag     = {3'd0, shifted[43:15]};
    if (is_zero) begin
      mag_out = '0;
    end else if (a_neg ^ b_neg) begin
      mag_out = ~mag;
    end else begin
      mag_out = mag;
    end
  end

endmodule

`default_nettype wire

// ===== src/hybrid_radix4_log_approx_multiplier_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake                    | payload
// ----------+------------------------------+----------------------------------
// input     | in_valid / in_ready          | in_multiplicand, in_multiplier
// result    | out_valid / out_ready        | out_product
// config    | psel penable pwrite pready   | paddr, pwdata, prdata
//
// one request per cycle sustained while the result channel is not stalled
// stage one is the input register, stage two the result register
// all arithmetic sits between the two in a single pass
// reset (rst_n, sync) empties both stages and sets mantissa_keep_bits to 3
// a stalled result holds stage two; stage one still takes one more request

module hybrid_radix4_log_approx_multiplier_top (
  input  wire                                      clk,
  input  wire                                      rst_n,
  input  wire                                      in_valid,
  output logic                                     in_ready,
  input  wire signed [hrlam_pkg::OPND_W-1:0]       in_multiplicand,
  input  wire signed [hrlam_pkg::OPND_W-1:0]       in_multiplier,
  output logic                                     out_valid,
  input  wire                                      out_ready,
  output logic signed [hrlam_pkg::PROD_W-1:0]      out_product,
  input  wire                                      psel,
  input  wire                                      penable,
  input  wire                                      pwrite,
  input  wire [2:0]                                paddr,
  input  wire [31:0]                               pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);

`include "hybrid_radix4_log_approx_multiplier_top_assert.svh"

  logic [hrlam_pkg::MANT_W-1:0] mant_keep_r, mant_keep_nxt;
  hrlam_pkg::reg_idx_t          reg_idx;
  logic                         cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = hrlam_pkg::reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    mant_keep_nxt = mant_keep_r;
    prdata        = '0;
    unique case (reg_idx)
      hrlam_pkg::REG_MANT_KEEP: begin
        prdata = {28'd0, mant_keep_r};
        if (cfg_wr) begin
          mant_keep_nxt = pwdata[hrlam_pkg::MANT_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mant_keep_r <= hrlam_pkg::MANT_KEEP_RESET;
    end else begin
      mant_keep_r <= mant_keep_nxt;
    end
  end

  // pipeline control
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic adv;
  logic signed [hrlam_pkg::OPND_W-1:0] s1_multiplicand_r, s1_multiplier_r;
  logic signed [hrlam_pkg::PROD_W-1:0] out_product_r, out_product_nxt;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_product = out_product_r;

  always_comb begin
    s1_valid_nxt  = in_ready ? in_valid : s1_valid_r;
    out_valid_nxt = adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_multiplicand_r <= in_multiplicand;
      s1_multiplier_r   <= in_multiplier;
    end
    if (s1_valid_r && adv) begin
      out_product_r <= out_product_nxt;
    end
  end

  // radix-4 split: x = digit * 2^14 + low, low in -8192..8192
  logic [13:0]                         low_u;
  logic signed [hrlam_pkg::LOW_W-1:0]  low;
  logic [16:0]                         diff;
  logic signed [2:0]                   digit;
  logic signed [18:0]                  pp1;
  logic [31:0]                         hi32, hi_adj;
  logic [hrlam_pkg::MANT_W-1:0]        w_eff;
  hrlam_pkg::log_opnd_t                log_opnd;
  logic [hrlam_pkg::PROD_W-1:0]        log_mag;

  always_comb begin
    low_u = s1_multiplicand_r[13:0];
    if (low_u == 14'h2000 && !s1_multiplicand_r[15]) begin
      low = 15'sh2000;
    end else begin
      low = {low_u[13], low_u};
    end
    diff  = {s1_multiplicand_r[15], s1_multiplicand_r} - {{2{low[14]}}, low};
    digit = diff[16:14];
    pp1   = digit * s1_multiplier_r;
    hi32  = {{13{pp1[18]}}, pp1};
    hi_adj = pp1[18] ? ((hi32 - 32'd1) | 32'd1) : hi32;
    w_eff = (mant_keep_r == '0) ? hrlam_pkg::MANT_KEEP_MIN : mant_keep_r;
    log_opnd.low       = low;
    log_opnd.mult      = s1_multiplier_r;
    log_opnd.keep_bits = w_eff;
    out_product_nxt = signed'((hi_adj << 14) + log_mag);
  end

  hrlam_log_path u_log_path (
    .opnd    (log_opnd),
    .mag_out (log_mag)
  );

  `HRLAM_ASSERT_NOW(a_stall_blocks_input, s1_valid_r && out_valid_r && !out_ready, !in_ready)
  `HRLAM_ASSERT_NEXT(a_stage_moves, s1_valid_r && adv, out_valid_r)
  `HRLAM_ASSERT_NEXT(a_zero_mult, s1_valid_r && adv && s1_multiplier_r == '0, out_product_r == '0)
  `HRLAM_ASSERT_NEXT(a_empty_pipe_idle, !s1_valid_r && !in_valid && adv, !out_valid_r)

endmodule

`default_nettype wire
